// File: rtl/core/hid_keyboard_report_sequencer_top_defines.svh
// ----------------------------------------------------------------------------
// hid_keyboard_report_sequencer_top_defines.svh
// Assertion macros shared by the report sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_SEQUENCER_TOP_DEFINES_SVH
`define HID_KEYBOARD_REPORT_SEQUENCER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define HKRS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HKRS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/hkrs_pkg.sv
// ----------------------------------------------------------------------------
// hkrs_pkg
// Constants, types and helpers of the keyboard report sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hkrs_pkg;

    localparam int KeyWords  = 4;
    localparam int WordBits  = 56;
    localparam int KeyBits   = KeyWords * WordBits;
    localparam int NumBytes  = KeyBits / 8;
    localparam int ByteIdxW  = $clog2(NumBytes);
    localparam int ModBits   = 8;
    localparam int KeyCodeW  = 8;
    localparam int BootSlots = 6;
    localparam int SlotW     = $clog2(BootSlots + 1);
    localparam int SlotIdxW  = $clog2(BootSlots);
    localparam int AddrW     = 3;
    localparam int DataW     = 32;

    // register index, decoded from paddr[2]
    localparam logic RegBootProtocol = 1'b0;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PLAN = 5'b00010,
        S_LOAD = 5'b00100,
        S_SCAN = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // reports still owed for the current item, in send order
    typedef struct packed {
        logic rel;   // plain keys dropped after a modifier release
        logic mods;  // modifier change
        logic full;  // everything else
    } t_steps;

    // position of the lowest set bit of a byte (0 when empty)
    function automatic logic [2:0] lowest_bit(input logic [7:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (b[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

// File: rtl/core/hid_keyboard_report_sequencer_top.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_sequencer_top
// Turns keyboard states into an ordered series of HID keyboard reports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one keyboard state item:
//   8 modifier bits plus a 224-bit keycode bitmap in four 56-bit words.
//   Output channel (o_out_valid / i_out_stall) delivers 0 to 3 report items
//   per input item; o_last_report marks the final one. An unchanged state
//   produces no report.
//   The block handles one item at a time and stalls input until the last
//   report of the item is taken. Bitmap mode: each report is a load, then
//   the send. Boot mode: the six-key list is built by one byte-wide
//   lowest-bit finder walking the 28 bitmap bytes, one byte fetch or one
//   listed keycode per cycle; each report is a load, the byte steps and
//   listings, then the send. A stalled report holds all of its fields;
//   nothing advances meanwhile. Reset clears the sent state and selects
//   bitmap mode. APB register 0 (boot_protocol) must be written only while
//   the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hid_keyboard_report_sequencer_top_defines.svh"

module hid_keyboard_report_sequencer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // apb
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hkrs_pkg::AddrW-1:0]       paddr,
    input  logic [hkrs_pkg::DataW-1:0]       pwdata,
    output logic [hkrs_pkg::DataW-1:0]       prdata,
    output logic                             pready,
    // input items
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [hkrs_pkg::ModBits-1:0]     i_new_modifiers,
    input  logic [hkrs_pkg::WordBits-1:0]    i_key_word_0,
    input  logic [hkrs_pkg::WordBits-1:0]    i_key_word_1,
    input  logic [hkrs_pkg::WordBits-1:0]    i_key_word_2,
    input  logic [hkrs_pkg::WordBits-1:0]    i_key_word_3,
    // report items
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [hkrs_pkg::ModBits-1:0]     o_out_modifiers,
    output logic [hkrs_pkg::WordBits-1:0]    o_out_word_0,
    output logic [hkrs_pkg::WordBits-1:0]    o_out_word_1,
    output logic [hkrs_pkg::WordBits-1:0]    o_out_word_2,
    output logic [hkrs_pkg::WordBits-1:0]    o_out_word_3,
    output logic [hkrs_pkg::KeyCodeW-1:0]    o_boot_key_0,
    output logic [hkrs_pkg::KeyCodeW-1:0]    o_boot_key_1,
    output logic [hkrs_pkg::KeyCodeW-1:0]    o_boot_key_2,
    output logic [hkrs_pkg::KeyCodeW-1:0]    o_boot_key_3,
    output logic [hkrs_pkg::KeyCodeW-1:0]    o_boot_key_4,
    output logic [hkrs_pkg::KeyCodeW-1:0]    o_boot_key_5,
    output logic                             o_last_report
);

    import hkrs_pkg::*;

    t_state                r_state,         n_state;
    logic                  r_boot_protocol, n_boot_protocol;
    logic [ModBits-1:0]    r_sent_mod,      n_sent_mod;
    logic [KeyBits-1:0]    r_sent_keys,     n_sent_keys;
    logic [ModBits-1:0]    r_new_mod,       n_new_mod;
    logic [KeyBits-1:0]    r_new_keys,      n_new_keys;
    t_steps                r_steps,         n_steps;
    logic                  r_last,          n_last;
    logic [ByteIdxW-1:0]   r_byte_idx,      n_byte_idx;
    logic [7:0]            r_byte_bits,     n_byte_bits;
    logic [SlotW-1:0]      r_slot,          n_slot;
    logic [KeyCodeW-1:0]   r_boot_keys [BootSlots];
    logic [KeyCodeW-1:0]   n_boot_keys [BootSlots];

    logic                  w_cfg_wr;
    logic                  w_released;
    logic                  w_gone;
    logic                  w_rel;
    logic                  w_full;
    logic [KeyBits-1:0]    w_keys_after;
    logic [2:0]            w_bit;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == RegBootProtocol) ?
                      {{(DataW-1){1'b0}}, r_boot_protocol} : '0;

    // which reports this item owes
    assign w_released   = |(r_sent_mod & ~r_new_mod);
    assign w_gone       = |(r_sent_keys & ~r_new_keys);
    assign w_rel        = w_released && w_gone;
    assign w_keys_after = w_rel ? (r_sent_keys & r_new_keys) : r_sent_keys;
    assign w_full       = (w_keys_after != r_new_keys);

    assign w_bit = lowest_bit(r_byte_bits);

    always_comb begin
        n_state         = r_state;
        n_boot_protocol = r_boot_protocol;
        n_sent_mod      = r_sent_mod;
        n_sent_keys     = r_sent_keys;
        n_new_mod       = r_new_mod;
        n_new_keys      = r_new_keys;
        n_steps         = r_steps;
        n_last          = r_last;
        n_byte_idx      = r_byte_idx;
        n_byte_bits     = r_byte_bits;
        n_slot          = r_slot;
        n_boot_keys     = r_boot_keys;

        if (w_cfg_wr && paddr[2] == RegBootProtocol) begin
            n_boot_protocol = pwdata[0];
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_new_mod  = i_new_modifiers;
                    n_new_keys = {i_key_word_3, i_key_word_2, i_key_word_1, i_key_word_0};
                    n_state    = S_PLAN;
                end
            end
            S_PLAN: begin
                n_steps.rel  = w_rel;
                n_steps.mods = (r_sent_mod != r_new_mod);
                n_steps.full = w_full;
                if (w_rel || w_full || (r_sent_mod != r_new_mod)) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                // apply the next owed step to the sent state
                if (r_steps.rel) begin
                    n_sent_keys = r_sent_keys & r_new_keys;
                    n_steps.rel = 1'b0;
                    n_last      = !(r_steps.mods || r_steps.full);
                end else if (r_steps.mods) begin
                    n_sent_mod   = r_new_mod;
                    n_steps.mods = 1'b0;
                    n_last       = !r_steps.full;
                end else begin
                    n_sent_mod   = r_new_mod;
                    n_sent_keys  = r_new_keys;
                    n_steps.full = 1'b0;
                    n_last       = 1'b1;
                end
                for (int s = 0; s < BootSlots; s++) begin
                    n_boot_keys[s] = '0;
                end
                n_slot      = '0;
                n_byte_idx  = '0;
                n_byte_bits = n_sent_keys[7:0];
                n_state     = r_boot_protocol ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                if (r_byte_bits != 8'd0) begin
                    n_boot_keys[r_slot[SlotIdxW-1:0]] = {r_byte_idx, w_bit};
                    n_byte_bits = r_byte_bits & (r_byte_bits - 8'd1);
                    n_slot      = r_slot + SlotW'(1);
                    if (n_slot == SlotW'(BootSlots)) begin
                        n_state = S_OUT;
                    end
                end else if (r_byte_idx == ByteIdxW'(NumBytes - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_byte_idx  = r_byte_idx + ByteIdxW'(1);
                    n_byte_bits = r_sent_keys[{n_byte_idx, 3'b000} +: 8];
                end
            end
            S_OUT: begin
                if (!i_out_stall) begin
                    n_state = r_last ? S_IDLE : S_LOAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_boot_protocol <= 1'b0;
            r_sent_mod      <= '0;
            r_sent_keys     <= '0;
            r_steps         <= '0;
            r_last          <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_boot_protocol <= n_boot_protocol;
            r_sent_mod      <= n_sent_mod;
            r_sent_keys     <= n_sent_keys;
            r_steps         <= n_steps;
            r_last          <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_new_mod   <= n_new_mod;
        r_new_keys  <= n_new_keys;
        r_byte_idx  <= n_byte_idx;
        r_byte_bits <= n_byte_bits;
        r_slot      <= n_slot;
        r_boot_keys <= n_boot_keys;
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = (r_state == S_OUT);
    assign o_out_modifiers = r_sent_mod;
    assign o_out_word_0    = r_sent_keys[0*WordBits +: WordBits];
    assign o_out_word_1    = r_sent_keys[1*WordBits +: WordBits];
    assign o_out_word_2    = r_sent_keys[2*WordBits +: WordBits];
    assign o_out_word_3    = r_sent_keys[3*WordBits +: WordBits];
    assign o_boot_key_0    = r_boot_keys[0];
    assign o_boot_key_1    = r_boot_keys[1];
    assign o_boot_key_2    = r_boot_keys[2];
    assign o_boot_key_3    = r_boot_keys[3];
    assign o_boot_key_4    = r_boot_keys[4];
    assign o_boot_key_5    = r_boot_keys[5];
    assign o_last_report   = r_last;

    // final report of an item always carries the full new state
    `HKRS_ASSERT_IMP(a_last_is_new, o_out_valid && o_last_report, (r_sent_mod == r_new_mod) && (r_sent_keys == r_new_keys), "last report differs from new state")
    // taking the last report frees the input side
    `HKRS_ASSERT_NXT(a_last_frees, o_out_valid && !i_out_stall && o_last_report, !o_in_stall, "input not released after last report")
    // taking an earlier report keeps the input side stalled
    `HKRS_ASSERT_NXT(a_more_holds, o_out_valid && !i_out_stall && !o_last_report, o_in_stall, "input released before last report")
    // boot list stays ascending
    `HKRS_ASSERT_IMP(a_boot_order, o_out_valid && o_boot_key_1 != '0, o_boot_key_1 > o_boot_key_0, "boot keycodes out of order")
    // bitmap mode never lists keycodes
    `HKRS_ASSERT_IMP(a_bitmap_empty, o_out_valid && !r_boot_protocol, (o_boot_key_0 == '0) && (o_boot_key_5 == '0), "boot list filled in bitmap mode")

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyboard report sequencer. A scoreboard class
// tracks the last sent keyboard state, predicts the release / modifier / full
// reports that each accepted state item owes, and checks every accepted
// report field by field. Directed states come first in both output modes,
// then random typing-like sequences under changing idle patterns.
// ----------------------------------------------------------------------------
module tb;
    import hkrs_pkg::*;

    localparam int RegIdxBoot     = 0;
    localparam int RegIdxUnused   = 1;  // no such register, writes must be dropped
    localparam int QuietCycles    = 40;
    localparam int WatchdogLimit  = 5000;
    localparam int RandomPerPhase = 35;

    typedef logic [KeyWords-1:0][WordBits-1:0] t_key_words;

    typedef struct packed {
        logic [ModBits-1:0] mods;
        t_key_words         keys;
    } t_key_state;

    typedef struct packed {
        logic [ModBits-1:0]                  mods;
        t_key_words                          keys;
        logic [BootSlots-1:0][KeyCodeW-1:0]  boot;
        logic                                last;
    } t_hid_report;

    class t_report_scoreboard;
        logic               boot_list_on;
        logic [ModBits-1:0] held_mods;
        t_key_words         held_keys;
        t_hid_report        owed[$];
        int unsigned        errors;

        function new();
            boot_list_on = 1'b0;
            held_mods    = '0;
            held_keys    = '0;
            errors       = 0;
        endfunction

        function void set_reg(input int idx, input logic [DataW-1:0] value);
            if (idx == RegIdxBoot) begin
                boot_list_on = value[0];
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // report built from the currently held state
        function t_hid_report snapshot();
            t_hid_report r;
            int          slot;
            r.mods = held_mods;
            r.keys = held_keys;
            r.boot = '0;
            r.last = 1'b0;
            slot   = 0;
            if (boot_list_on) begin
                for (int code = 0; code < KeyBits && slot < BootSlots; code++) begin
                    if (held_keys[code / WordBits][code % WordBits]) begin
                        r.boot[slot] = KeyCodeW'(code);
                        slot++;
                    end
                end
            end
            return r;
        endfunction

        function void note_state(input t_key_state s);
            t_key_words  gone;
            t_hid_report r;
            int          first;
            first = owed.size();
            // released modifier: drop vanished plain keys first
            if ((held_mods & ~s.mods) != '0) begin
                gone = held_keys & ~s.keys;
                if (gone != '0) begin
                    held_keys = held_keys & ~gone;
                    owed.push_back(snapshot());
                end
            end
            if (held_mods != s.mods) begin
                held_mods = s.mods;
                owed.push_back(snapshot());
            end
            if (held_keys != s.keys) begin
                held_keys = s.keys;
                owed.push_back(snapshot());
            end
            if (owed.size() > first) begin
                r      = owed.pop_back();
                r.last = 1'b1;
                owed.push_back(r);
            end
        endfunction

        function void check_report(input t_hid_report got);
            t_hid_report want;
            if (owed.size() == 0) begin
                $error("unexpected report: out_modifiers %h last_report %b",
                       got.mods, got.last);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.mods !== want.mods) begin
                $error("out_modifiers: expected %h, actual %h", want.mods, got.mods);
                errors++;
            end
            for (int w = 0; w < KeyWords; w++) begin
                if (got.keys[w] !== want.keys[w]) begin
                    $error("out_word_%0d: expected %h, actual %h", w, want.keys[w],
                           got.keys[w]);
                    errors++;
                end
            end
            for (int k = 0; k < BootSlots; k++) begin
                if (got.boot[k] !== want.boot[k]) begin
                    $error("boot_key_%0d: expected %0d, actual %0d", k, want.boot[k],
                           got.boot[k]);
                    errors++;
                end
            end
            if (got.last !== want.last) begin
                $error("last_report: expected %b, actual %b", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  psel            = 1'b0;
    logic                  penable         = 1'b0;
    logic                  pwrite          = 1'b0;
    logic [AddrW-1:0]      paddr           = '0;
    logic [DataW-1:0]      pwdata          = '0;
    logic [DataW-1:0]      prdata;
    logic                  pready;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [ModBits-1:0]    i_new_modifiers = '0;
    logic [WordBits-1:0]   i_key_word_0    = '0;
    logic [WordBits-1:0]   i_key_word_1    = '0;
    logic [WordBits-1:0]   i_key_word_2    = '0;
    logic [WordBits-1:0]   i_key_word_3    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [ModBits-1:0]    o_out_modifiers;
    logic [WordBits-1:0]   o_out_word_0;
    logic [WordBits-1:0]   o_out_word_1;
    logic [WordBits-1:0]   o_out_word_2;
    logic [WordBits-1:0]   o_out_word_3;
    logic [KeyCodeW-1:0]   o_boot_key_0;
    logic [KeyCodeW-1:0]   o_boot_key_1;
    logic [KeyCodeW-1:0]   o_boot_key_2;
    logic [KeyCodeW-1:0]   o_boot_key_3;
    logic [KeyCodeW-1:0]   o_boot_key_4;
    logic [KeyCodeW-1:0]   o_boot_key_5;
    logic                  o_last_report;

    t_report_scoreboard sb;
    t_key_state         prev_state = '0;
    int unsigned        gap_pct    = 0;
    int unsigned        stall_pct  = 0;
    int unsigned        quiet      = 0;

    hid_keyboard_report_sequencer_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_new_modifiers (i_new_modifiers),
        .i_key_word_0    (i_key_word_0),
        .i_key_word_1    (i_key_word_1),
        .i_key_word_2    (i_key_word_2),
        .i_key_word_3    (i_key_word_3),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_modifiers (o_out_modifiers),
        .o_out_word_0    (o_out_word_0),
        .o_out_word_1    (o_out_word_1),
        .o_out_word_2    (o_out_word_2),
        .o_out_word_3    (o_out_word_3),
        .o_boot_key_0    (o_boot_key_0),
        .o_boot_key_1    (o_boot_key_1),
        .o_boot_key_2    (o_boot_key_2),
        .o_boot_key_3    (o_boot_key_3),
        .o_boot_key_4    (o_boot_key_4),
        .o_boot_key_5    (o_boot_key_5),
        .o_last_report   (o_last_report)
    );

    always #10 i_clk = ~i_clk;

    // report side: check accepted reports, stall at random
    always @(posedge i_clk) begin
        t_hid_report seen;
        seen.mods = o_out_modifiers;
        seen.keys = {o_out_word_3, o_out_word_2, o_out_word_1, o_out_word_0};
        seen.boot = {o_boot_key_5, o_boot_key_4, o_boot_key_3,
                     o_boot_key_2, o_boot_key_1, o_boot_key_0};
        seen.last = o_last_report;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_report(seen);
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet >= WatchdogLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_state(input t_key_state s);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_new_modifiers <= s.mods;
        i_key_word_0    <= s.keys[0];
        i_key_word_1    <= s.keys[1];
        i_key_word_2    <= s.keys[2];
        i_key_word_3    <= s.keys[3];
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_state(s);
        prev_state = s;
    endtask

    task automatic send_keys(input logic [ModBits-1:0] mods, input logic [WordBits-1:0] w3,
                             input logic [WordBits-1:0] w2, input logic [WordBits-1:0] w1,
                             input logic [WordBits-1:0] w0);
        t_key_state s;
        s.mods = mods;
        s.keys = {w3, w2, w1, w0};
        send_state(s);
    endtask

    // waits for the block to drain, then writes one register
    task automatic settle_and_write(input int idx, input logic [DataW-1:0] value);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (QuietCycles) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'(4 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    function automatic logic [WordBits-1:0] rand_word();
        return WordBits'({$urandom, $urandom});
    endfunction

    // mostly typing-like evolution of the previous state, some noise
    function automatic t_key_state next_state(input t_key_state p);
        t_key_state  s;
        int unsigned kind;
        int unsigned code;
        int unsigned n;
        s    = p;
        kind = $urandom_range(99);
        if (kind < 45) begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
                code = $urandom_range(KeyBits - 1);
                s.keys[code / WordBits][code % WordBits] ^= 1'b1;
            end
            if ($urandom_range(99) < 40) begin
                s.mods[$urandom_range(ModBits - 1)] ^= 1'b1;
            end
        end else if (kind < 60) begin
            // modifier release together with plain key releases
            s.mods = s.mods & ModBits'($urandom);
            for (int w = 0; w < KeyWords; w++) begin
                s.keys[w] = s.keys[w] & rand_word();
            end
            code = $urandom_range(KeyBits - 1);
            s.keys[code / WordBits][code % WordBits] = 1'b1;
        end else if (kind < 70) begin
            s = p;
        end else if (kind < 85) begin
            s.mods = ModBits'($urandom);
            s.keys = '0;
            n      = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                code = $urandom_range(KeyBits - 1);
                s.keys[code / WordBits][code % WordBits] = 1'b1;
            end
        end else begin
            s.mods = ModBits'($urandom);
            for (int w = 0; w < KeyWords; w++) begin
                s.keys[w] = rand_word();
            end
        end
        return s;
    endfunction

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            send_state(next_state(prev_state));
        end
    endtask

    initial begin
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        gap_pct   = 7;
        stall_pct = 77;

        // bitmap mode after reset
        send_keys(8'h00, '0, '0, '0, '0);                      // unchanged
        send_keys(8'hFF, '1, '1, '1, '1);                      // everything pressed
        send_keys(8'h00, '0, '0, '0, '0);                      // release all: 2 reports
        send_keys(8'h01, '0, '0, '0, 56'h10);
        send_keys(8'h00, '0, '0, '0, 56'h30);                  // mod release, no key gone
        send_keys(8'h00, '0, '0, '0, 56'h30);                  // unchanged
        send_keys(8'h80, 56'h80_0000_0000_0000, '0, '0, '0);  // keycode 223 only
        send_keys(8'h80, '0, '0, '0, 56'h1);                   // keys only

        settle_and_write(RegIdxBoot, 32'hFFFF_FFFF);
        settle_and_write(RegIdxUnused, 32'h0000_0000);

        // boot mode
        send_keys(8'h00, '0, '0, '0, 56'h7);                   // fewer than six keys
        send_keys(8'h00, '0, '0, '0, 56'hFF);                  // more than six keys
        send_keys(8'h55, 56'h80_0000_0000_0001, 56'h80_0000_0000_0001,
                  56'h80_0000_0000_0001, 56'h80_0000_0000_0000);  // word edges
        send_keys(8'hAA, '1, '1, '1, '1);
        send_keys(8'h00, 56'h80_0000_0000_0000, '0, '0, '0);  // mod and key release
        send_keys(8'h00, '0, '0, '0, '0);
        send_keys(8'h00, 56'h100_0000, '0, '0, '0);            // single key in last word
        send_keys(8'h00, 56'h100_0000, '0, '0, '0);            // unchanged

        settle_and_write(RegIdxBoot, 32'hFFFF_FFFE);
        run_random(RandomPerPhase);

        settle_and_write(RegIdxBoot, 32'h0000_0001);
        gap_pct   = 77;
        stall_pct = 7;
        run_random(RandomPerPhase);

        settle_and_write(RegIdxUnused, 32'hFFFF_FFFF);
        gap_pct   = 0;
        stall_pct = 0;
        run_random(RandomPerPhase);

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (QuietCycles) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
